@@ rtl/tlc_pkg.sv @@
// Shared types, character codes and class codes for the token literal classifier.
package tlc_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    localparam int CH_W    = 8;
    localparam int CLASS_W = 3;
    localparam int TDATA_W = 8;

    typedef enum logic [CLASS_W-1:0] {
        CLS_POS_INT   = 3'd0,
        CLS_NEG_INT   = 3'd1,
        CLS_POS_FLOAT = 3'd2,
        CLS_NEG_FLOAT = 3'd3,
        CLS_IDENT     = 3'd4,
        CLS_ERROR     = 3'd5
    } t_class;

    typedef struct packed {
        logic [1:0]      char_count;
        logic [CH_W-1:0] first_char;
        logic [CH_W-1:0] second_char;
        logic            seen_dot;
        logic            seen_letter;
        logic            seen_digit;
        logic            is_negative;
        logic            error_seen;
        logic            last_was_dot;
    } t_tok_state;

    localparam t_tok_state TOK_STATE_CLEAR = '{
        char_count:   2'd0,
        first_char:   '0,
        second_char:  '0,
        seen_dot:     1'b0,
        seen_letter:  1'b0,
        seen_digit:   1'b0,
        is_negative:  1'b0,
        error_seen:   1'b0,
        last_was_dot: 1'b0
    };

endpackage

@@ rtl/token_literal_classifier.sv @@
// Top level of the token literal classifier with input and result registers.
// A space beat passes through the input register and then the result register before it leaves as a result beat.
// Throughput: one character beat per cycle; only a stalled result register holds back a space.
// Each character is decided by the flag update logic between the input and result registers.
// Reset (i_rst_n low, synchronous) empties both registers and clears the token state.
module token_literal_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tlc_pkg::TDATA_W-1:0]   i_s_tdata,  // [7:0] ch
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tlc_pkg::TDATA_W-1:0]   o_m_tdata   // [2:0] token_class, [7:3] zero
);

    logic                     r_in_valid;
    logic [tlc_pkg::CH_W-1:0] r_in_ch;
    logic                     r_out_valid;
    tlc_pkg::t_class          r_out_class;

    logic            w_result;
    tlc_pkg::t_class w_class;
    logic [1:0]      w_char_count;
    logic            w_out_free;
    logic            w_fire;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_fire     = r_in_valid && (!w_result || w_out_free);
    assign o_s_tready = !r_in_valid || w_fire;

    tlc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_ch         (r_in_ch),
        .o_result     (w_result),
        .o_class      (w_class),
        .o_char_count (w_char_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_result) begin
            r_out_class <= w_class;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(tlc_pkg::TDATA_W - tlc_pkg::CLASS_W){1'b0}}, r_out_class};

    a_space_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_result) |=> o_m_tvalid)
        else $error("space beat did not produce a result beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !(w_fire && w_result))
        else $error("result register overwritten while stalled");

    a_space_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_result) |=> (w_char_count == 2'd0))
        else $error("token state not cleared after a space");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("registers not empty after reset");

endmodule

@@ rtl/tlc_core.sv @@
// Token state register with the per-character update and the class decision.
module tlc_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [tlc_pkg::CH_W-1:0]   i_ch,
    output logic                       o_result,
    output tlc_pkg::t_class            o_class,
    output logic [1:0]                 o_char_count
);

    tlc_pkg::t_tok_state r_st;
    tlc_pkg::t_tok_state n_st;
    tlc_pkg::t_tok_state w_body;

    logic w_is_space;
    logic w_is_dot;
    logic w_is_digit;
    logic w_is_letter;

    assign w_is_space  = (i_ch == tlc_pkg::CH_SPACE);
    assign w_is_dot    = (i_ch == tlc_pkg::CH_DOT);
    assign w_is_digit  = (i_ch >= tlc_pkg::CH_ZERO) && (i_ch <= tlc_pkg::CH_NINE);
    assign w_is_letter = ((i_ch >= tlc_pkg::CH_UC_A) && (i_ch <= tlc_pkg::CH_UC_Z)) ||
                         ((i_ch >= tlc_pkg::CH_LC_A) && (i_ch <= tlc_pkg::CH_LC_Z)) ||
                         (i_ch == tlc_pkg::CH_UNDER);

    // Body update of the flags, applied to every token byte except a leading minus.
    always_comb begin
        w_body = r_st;
        if (w_is_dot) begin
            if (r_st.seen_dot || r_st.seen_letter) begin
                w_body.error_seen = 1'b1;
            end
            w_body.seen_dot = 1'b1;
        end else if (w_is_digit) begin
            w_body.seen_digit = 1'b1;
        end else if (w_is_letter) begin
            if (r_st.seen_digit && !r_st.seen_letter) begin
                w_body.error_seen = 1'b1;
            end
            w_body.seen_letter = 1'b1;
        end else begin
            w_body.error_seen = 1'b1;
        end
    end

    always_comb begin
        n_st = r_st;
        if (w_is_space) begin
            n_st = tlc_pkg::TOK_STATE_CLEAR;
        end else begin
            if (r_st.char_count == 2'd0) begin
                if (i_ch == tlc_pkg::CH_MINUS) begin
                    n_st.is_negative = 1'b1;
                end else begin
                    n_st = w_body;
                end
                n_st.first_char = i_ch;
            end else begin
                n_st = w_body;
                if (r_st.char_count == 2'd1) begin
                    n_st.second_char = i_ch;
                end
            end
            n_st.last_was_dot = w_is_dot;
            if (r_st.char_count != 2'd3) begin
                n_st.char_count = r_st.char_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tlc_pkg::TOK_STATE_CLEAR;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

    logic w_err;

    always_comb begin
        w_err = r_st.error_seen || r_st.last_was_dot;
        if ((r_st.char_count != 2'd0) && (r_st.first_char == tlc_pkg::CH_DOT)) begin
            w_err = 1'b1;
        end
        if ((r_st.char_count >= 2'd2) && (r_st.first_char == tlc_pkg::CH_ZERO) &&
            !((r_st.char_count == 2'd3) && (r_st.second_char == tlc_pkg::CH_DOT))) begin
            w_err = 1'b1;
        end
        if ((r_st.char_count == 2'd2) && (r_st.first_char == tlc_pkg::CH_MINUS) &&
            (r_st.second_char == tlc_pkg::CH_ZERO)) begin
            w_err = 1'b1;
        end

        if ((r_st.char_count == 2'd1) && (r_st.first_char == tlc_pkg::CH_ZERO)) begin
            o_class = tlc_pkg::CLS_POS_INT;
        end else if (w_err) begin
            o_class = tlc_pkg::CLS_ERROR;
        end else if (r_st.seen_letter) begin
            o_class = tlc_pkg::CLS_IDENT;
        end else if (r_st.seen_dot) begin
            o_class = r_st.is_negative ? tlc_pkg::CLS_NEG_FLOAT : tlc_pkg::CLS_POS_FLOAT;
        end else begin
            o_class = r_st.is_negative ? tlc_pkg::CLS_NEG_INT : tlc_pkg::CLS_POS_INT;
        end
    end

    assign o_result     = w_is_space;
    assign o_char_count = r_st.char_count;

endmodule
